// ===== hw/rtl/spiral_index_to_coordinate_top_defines.svh =====
// assertion macros shared by the spiral index to coordinate rtl
`ifndef SPIRAL_INDEX_TO_COORDINATE_TOP_DEFINES_SVH
`define SPIRAL_INDEX_TO_COORDINATE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SIT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sit assertion failed");
// next-cycle implication
`define SIT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sit assertion failed");
`else
`define SIT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SIT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/sit_pkg.sv =====
// types and constants for the spiral index to coordinate block
package sit_pkg;

  // widest radicand carried between front and back
  localparam int MAX_RAD_BITS = 31;
  // coordinate width on the output ports
  localparam int COORD_BITS   = 16;
  // depth of the queue between front and back
  localparam int QUEUE_DEPTH  = 2;

  // word handed from front to back
  typedef struct packed {
    logic                    bad;
    logic [MAX_RAD_BITS-1:0] rad;   // index minus one
  } sit_word_t;

endpackage

// ===== hw/rtl/sit_front.sv =====
// front end: takes the index, flags bad values and forms index minus one
module sit_front import sit_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] index,
  input  logic               q_full,
  output logic               q_push,
  output sit_word_t          q_word
);

  logic [INDEX_BITS-1:0] v;

  // only the low index bits count, as a two's complement value
  assign v = index[INDEX_BITS-1:0];

  // classify and hand over
  always_comb begin
    q_word.bad = (v == '0) || v[INDEX_BITS-1];
    q_word.rad = MAX_RAD_BITS'(v[INDEX_BITS-2:0]) - MAX_RAD_BITS'(1);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/sit_queue.sv =====
// short queue between front and back
module sit_queue import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  sit_word_t push_word,
  output logic      full,
  output logic      q_valid,
  input  logic      q_stall,
  output sit_word_t q_word
);
  `include "spiral_index_to_coordinate_top_defines.svh"

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sit_word_t     mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign pop     = q_valid && !q_stall;
  assign q_word  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  `SIT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `SIT_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)
  `SIT_ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - 1'b1)

endmodule

// ===== hw/rtl/sit_back.sv =====
// back end: pipelined integer square root, then the walk along the ring
module sit_back import sit_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_stall,
  input  sit_word_t                    q_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] x_pos,
  output logic signed [COORD_BITS-1:0] y_pos,
  output logic                         bad_index
);
  `include "spiral_index_to_coordinate_top_defines.svh"

  localparam int NB   = INDEX_BITS - 1;   // radicand bits
  localparam int QB   = (NB + 1) / 2;     // root bits, one stage each
  localparam int RW   = 2 * QB;
  localparam int REMW = QB + 2;
  localparam int CW   = QB + 3;
  localparam logic signed [CW-1:0] ONE = CW'(1);

  logic          en;
  logic          pop;
  logic [QB:0]   vld;
  logic [QB:0]   bad;
  logic [RW-1:0]   rad  [QB+1];
  logic [REMW-1:0] rem  [QB+1];
  logic [QB-1:0]   root [QB+1];
  logic [RW-1:0]   rad_next  [QB];
  logic [REMW-1:0] rem_next  [QB];
  logic [QB-1:0]   root_next [QB];

  logic signed [CW-1:0] sx, rx, kx, dx, xc, yc;
  logic                 near;

  // whole pipe moves unless the result register is held
  assign en      = !out_valid || !out_stall;
  assign pop     = en && q_valid;
  assign q_stall = !en;

  // one root bit per stage, restoring form
  always_comb begin
    for (int j = 0; j < QB; j++) begin
      logic [REMW+1:0] cur;
      logic [REMW+1:0] trial;
      logic            ge;
      cur   = {rem[j], rad[j][RW-1 -: 2]};
      trial = (REMW+2)'({root[j], 2'b01});
      ge    = (cur >= trial);
      rem_next[j]  = ge ? REMW'(cur - trial) : REMW'(cur);
      root_next[j] = {root[j][QB-2:0], ge};
      rad_next[j]  = rad[j] << 2;
    end
  end

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[QB-1:0], pop};
      out_valid <= vld[QB];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      bad[0]  <= q_word.bad;
      rad[0]  <= RW'(q_word.rad[NB-1:0]);
      rem[0]  <= '0;
      root[0] <= '0;
      for (int j = 0; j < QB; j++) begin
        bad[j+1]  <= bad[j];
        rad[j+1]  <= rad_next[j];
        rem[j+1]  <= rem_next[j];
        root[j+1] <= root_next[j];
      end
    end
  end

  // r = s + 1, k = r / 2, d = r*r - index = 2s - remainder
  always_comb begin
    sx   = CW'(root[QB]);
    rx   = sx + ONE;
    kx   = rx >>> 1;
    dx   = (sx <<< 1) - CW'(rem[QB]);
    near = (dx < rx);
    if (!root[QB][0]) begin
      // odd ring: from (k,-k) left, then up
      xc = near ? kx - dx : kx - sx;
      yc = near ? -kx : dx - sx - kx;
    end else begin
      // even ring: from (1-k,k) right, then down
      xc = near ? ONE - kx + dx : ONE - kx + sx;
      yc = near ? kx : kx - dx + sx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      bad_index <= bad[QB];
      x_pos     <= bad[QB] ? '0 : COORD_BITS'(xc);
      y_pos     <= bad[QB] ? '0 : COORD_BITS'(yc);
    end
  end

  `SIT_ASSERT_NOW(a_bad_zero, clk, rst, out_valid && bad_index, x_pos == '0 && y_pos == '0)
  `SIT_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(x_pos) && $stable(y_pos) && $stable(bad_index))
  `SIT_ASSERT_NOW(a_pop_free, clk, rst, pop, !(out_valid && out_stall))

endmodule

// ===== hw/rtl/spiral_index_to_coordinate_top.sv =====
// top level of the spiral index to coordinate block
// throughput: one word per cycle while out_stall is low, set by the square root pipe (one root bit per stage)
// a two-entry queue parts the input classifier from the root pipe
// reset (rst, synchronous) empties the queue and clears every stage valid bit
module spiral_index_to_coordinate_top import sit_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] x_pos,
  output logic signed [COORD_BITS-1:0] y_pos,
  output logic                         bad_index
);

  sit_word_t push_word;
  sit_word_t q_word;
  logic      q_full;
  logic      q_push;
  logic      q_valid;
  logic      q_stall;

  // classify incoming words
  sit_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .index    (index),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (push_word)
  );

  // decoupling queue
  sit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .q_word    (q_word)
  );

  // root pipe and coordinate walk
  sit_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .q_word    (q_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .bad_index (bad_index)
  );

endmodule
